// ===== src/assert_macros.svh =====
// Assertion macros used by the back part of the message buffer.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: %m");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: %m");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== src/pplmb_pkg.sv =====
// Shared types and constants of the ping-pong message buffer.
// No dependencies; imported by every module of the block.
`default_nettype none

package pplmb_pkg;

   // Field widths.
   localparam int OP_W     = 2;
   localparam int LEN_W    = 6;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;

   // Operation codes on the request side.
   localparam logic [OP_W-1:0] OP_WR_HDR  = 2'd0;
   localparam logic [OP_W-1:0] OP_WR_DATA = 2'd1;
   localparam logic [OP_W-1:0] OP_RD_MSG  = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd4;

   // Command queue between front and back, and result queue.
   localparam int CMD_DEPTH = 4;
   localparam int CMD_AW    = 2;
   localparam int CMD_CW    = 3;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_AW    = 2;
   localparam int RSP_CW    = 3;

   typedef enum logic [1:0] {
      CMD_HDR,
      CMD_DATA,
      CMD_READ,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [LEN_W-1:0]    length;
      logic [BYTE_W-1:0]   data;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   data;
      logic [LEN_W-1:0]    length;
      logic                last;
   } rsp_type;

   typedef enum logic [1:0] {
      BS_IDLE,
      BS_LEN,
      BS_DATA
   } back_state_type;

endpackage

`default_nettype wire

// ===== src/pingpong_length_prefixed_msg_buffer_core.sv =====
// Top level of the ping-pong message buffer: front, back and result queue.
// Depends on pplmb_pkg, pplmb_front, pplmb_back and pplmb_rsp_fifo.
//
// Two byte banks of BANK_BYTES each form a ping-pong message store: one takes
// writes, the other serves reads, and they swap when a read finds the read
// bank empty. A write header, a write data byte, a failed read or an unused
// operation each give one result from the back part. A successful read
// of a message first fetches the stored length, then receives it, then
// reads one byte per cycle, while the result queue has room, through the
// single read port of the byte store. A four-entry command queue parts the
// request side from the executing back part, and a four-entry result queue
// lets new requests come in while results wait to be popped. No clearing
// pass is needed after reset.
`default_nettype none

module pingpong_length_prefixed_msg_buffer_core
   import pplmb_pkg::*;
#(
   parameter int BANK_BYTES = 1024,
   parameter int MAX_MSG    = 63
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   output logic                     full,
   input  wire logic [OP_W-1:0]     req_op,
   input  wire logic [LEN_W-1:0]    req_msg_length,
   input  wire logic [BYTE_W-1:0]   req_data_in,
   output logic                     empty,
   input  wire logic                pop,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [BYTE_W-1:0]        rsp_data_out,
   output logic [LEN_W-1:0]         rsp_out_length,
   output logic                     rsp_last
);

   logic              cmd_valid;
   cmd_type           cmd;
   logic              cmd_pop;
   logic [RSP_CW-1:0] rsp_count;
   logic              rsp_push;
   rsp_type           rsp_push_data;
   rsp_type           rsp_head;

   // Request intake and classification.
   pplmb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_op         (req_op),
      .req_msg_length (req_msg_length),
      .req_data_in    (req_data_in),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   // Command execution against the banks.
   pplmb_back #(
      .BANK_BYTES (BANK_BYTES),
      .MAX_MSG    (MAX_MSG)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_push_data)
   );

   // Results waiting for transfer.
   pplmb_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_push_data),
      .pop       (pop),
      .empty     (empty),
      .head_data (rsp_head),
      .count     (rsp_count)
   );

   assign rsp_status     = rsp_head.status;
   assign rsp_data_out   = rsp_head.data;
   assign rsp_out_length = rsp_head.length;
   assign rsp_last       = rsp_head.last;

endmodule

`default_nettype wire

// ===== src/pplmb_front.sv =====
// Front part: accepts request transfers, classifies the operation and queues commands.
// Depends on pplmb_pkg.
`default_nettype none

module pplmb_front
   import pplmb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [OP_W-1:0]   req_op,
   input  wire logic [LEN_W-1:0]  req_msg_length,
   input  wire logic [BYTE_W-1:0] req_data_in,
   output logic                   cmd_valid,
   output cmd_type                cmd,
   input  wire logic              cmd_pop
);

   cmd_type             entry_ff [CMD_DEPTH];
   logic [CMD_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CW-1:0]   count_ff, count_in;
   cmd_type             new_cmd;
   logic                do_wr, do_rd;

   // Classify the incoming operation.
   always_comb begin
      new_cmd.length = req_msg_length;
      new_cmd.data   = req_data_in;
      case (req_op)
         OP_WR_HDR:  new_cmd.kind = CMD_HDR;
         OP_WR_DATA: new_cmd.kind = CMD_DATA;
         OP_RD_MSG:  new_cmd.kind = CMD_READ;
         default:    new_cmd.kind = CMD_NOP;
      endcase
   end

   // Queue occupancy and handshakes.
   assign full      = (count_ff == CMD_CW'(CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign do_wr     = push && !full;
   assign do_rd     = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CMD_CW'(do_wr) - CMD_CW'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage carries no reset.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== src/pplmb_back.sv =====
// Back part: executes queued commands against the two byte banks and forms results.
// Depends on pplmb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pplmb_back
   import pplmb_pkg::*;
#(
   parameter int BANK_BYTES = 1024,
   parameter int MAX_MSG    = 63
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire cmd_type           cmd,
   output logic                   cmd_pop,
   input  wire logic [RSP_CW-1:0] rsp_count,
   output logic                   rsp_push,
   output rsp_type                rsp_data
);

   localparam int PW = $clog2(BANK_BYTES + 1);
   localparam int AW = $clog2(2 * BANK_BYTES);
   localparam int SW = ((PW > 7) ? PW : 7) + 1;
   localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_MSG);

   // Byte store for both banks, bank 1 placed after bank 0.
   logic [BYTE_W-1:0] mem [2 * BANK_BYTES];
   logic [BYTE_W-1:0] mem_q_ff;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_wa, mem_ra;
   logic [BYTE_W-1:0] mem_wd;

   back_state_type    state_ff, state_in;
   logic [PW-1:0]     bank_used_ff [2];
   logic [PW-1:0]     bank_used_in [2];
   logic [PW-1:0]     bank_head_ff [2];
   logic [PW-1:0]     bank_head_in [2];
   logic              read_bank_ff, read_bank_in;
   logic [LEN_W-1:0]  wrem_ff, wrem_in;
   logic              discard_ff, discard_in;

   // Read progress of the message being emitted.
   logic              cur_bank_ff, cur_bank_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [LEN_W-1:0]  mlen_ff, mlen_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;

   // Result stage ahead of the result queue.
   logic                res_valid_ff, res_valid_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [LEN_W-1:0]    res_len_ff, res_len_in;
   logic                res_last_ff, res_last_in;
   logic                res_mem_ff, res_mem_in;

   logic              wb, rb_swap;
   logic              rd_empty_now, rd_empty_swap;
   logic [SW-1:0]     room, need;
   logic              no_space;
   logic [PW:0]       head_skip, pos_next;
   logic [RSP_CW:0]   occ;
   logic              credit;
   logic              last_byte;

   function automatic logic [AW-1:0] bank_addr(input logic bank, input logic [PW-1:0] pos);
      bank_addr = bank ? (AW'(BANK_BYTES) + AW'(pos)) : AW'(pos);
   endfunction

   // Bank selection and space checks.
   assign wb            = ~read_bank_ff;
   assign rb_swap       = ~read_bank_ff;
   assign rd_empty_now  = (bank_used_ff[read_bank_ff] == bank_head_ff[read_bank_ff]);
   assign rd_empty_swap = (bank_used_ff[rb_swap] == bank_head_ff[rb_swap]);
   assign room          = SW'(BANK_BYTES) - SW'(bank_used_ff[wb]);
   assign need          = SW'(cmd.length) + SW'(2);
   assign no_space      = (cmd.length > MAX_LEN) || (room < need);
   assign head_skip     = {1'b0, bank_head_ff[cur_bank_ff]} + (PW+1)'(2);
   assign pos_next      = {1'b0, pos_ff} + (PW+1)'(1);
   assign last_byte     = ((cnt_ff + LEN_W'(1)) == mlen_ff);

   // A result may be started only if the queue has room once the staged one lands.
   assign occ    = {1'b0, rsp_count} + (RSP_CW+1)'(res_valid_ff);
   assign credit = (occ < (RSP_CW+1)'(RSP_DEPTH));

   // Command sequencer.
   always_comb begin
      state_in      = state_ff;
      bank_used_in  = bank_used_ff;
      bank_head_in  = bank_head_ff;
      read_bank_in  = read_bank_ff;
      wrem_in       = wrem_ff;
      discard_in    = discard_ff;
      cur_bank_in   = cur_bank_ff;
      pos_in        = pos_ff;
      mlen_in       = mlen_ff;
      cnt_in        = cnt_ff;
      res_valid_in  = 1'b0;
      res_status_in = ST_OK;
      res_len_in    = '0;
      res_last_in   = 1'b1;
      res_mem_in    = 1'b0;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;
      mem_re        = 1'b0;
      mem_ra        = '0;
      case (state_ff)
         BS_IDLE: begin
            if (cmd_valid && credit) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  CMD_HDR: begin
                     res_valid_in = 1'b1;
                     if (wrem_ff != '0) begin
                        res_status_in = ST_BUSY;
                     end else if (cmd.length == '0) begin
                        res_status_in = ST_ZERO;
                     end else if (no_space) begin
                        res_status_in = ST_NOSPACE;
                        wrem_in       = cmd.length;
                        discard_in    = 1'b1;
                     end else begin
                        // The high length byte is always zero, so only the low one is kept.
                        mem_we           = 1'b1;
                        mem_wa           = bank_addr(wb, bank_used_ff[wb] + PW'(1));
                        mem_wd           = BYTE_W'(cmd.length);
                        bank_used_in[wb] = bank_used_ff[wb] + PW'(2);
                        wrem_in          = cmd.length;
                        discard_in       = 1'b0;
                     end
                  end
                  CMD_DATA: begin
                     res_valid_in = 1'b1;
                     if (wrem_ff != '0) begin
                        if (!discard_ff) begin
                           mem_we           = 1'b1;
                           mem_wa           = bank_addr(wb, bank_used_ff[wb]);
                           mem_wd           = cmd.data;
                           bank_used_in[wb] = bank_used_ff[wb] + PW'(1);
                        end
                        wrem_in = wrem_ff - LEN_W'(1);
                        if (wrem_ff == LEN_W'(1)) begin
                           discard_in = 1'b0;
                        end
                     end
                  end
                  CMD_READ: begin
                     if (wrem_ff != '0) begin
                        res_valid_in  = 1'b1;
                        res_status_in = ST_BUSY;
                     end else if (rd_empty_now && rd_empty_swap) begin
                        read_bank_in  = rb_swap;
                        res_valid_in  = 1'b1;
                        res_status_in = ST_EMPTY;
                     end else if (rd_empty_now) begin
                        read_bank_in = rb_swap;
                        cur_bank_in  = rb_swap;
                        mem_re       = 1'b1;
                        mem_ra       = bank_addr(rb_swap, bank_head_ff[rb_swap] + PW'(1));
                        state_in     = BS_LEN;
                     end else begin
                        cur_bank_in = read_bank_ff;
                        mem_re      = 1'b1;
                        mem_ra      = bank_addr(read_bank_ff,
                                                bank_head_ff[read_bank_ff] + PW'(1));
                        state_in    = BS_LEN;
                     end
                  end
                  default: begin
                     res_valid_in = 1'b1;
                  end
               endcase
            end
         end
         BS_LEN: begin
            if (mem_q_ff[LEN_W-1:0] == '0) begin
               // Empty message body: skip the length field only.
               res_valid_in = 1'b1;
               state_in     = BS_IDLE;
               if (head_skip >= {1'b0, bank_used_ff[cur_bank_ff]}) begin
                  bank_head_in[cur_bank_ff] = '0;
                  bank_used_in[cur_bank_ff] = '0;
               end else begin
                  bank_head_in[cur_bank_ff] = head_skip[PW-1:0];
               end
            end else begin
               mlen_in  = mem_q_ff[LEN_W-1:0];
               pos_in   = head_skip[PW-1:0];
               cnt_in   = '0;
               state_in = BS_DATA;
            end
         end
         BS_DATA: begin
            if (credit) begin
               mem_re       = 1'b1;
               mem_ra       = bank_addr(cur_bank_ff, pos_ff);
               pos_in       = pos_next[PW-1:0];
               cnt_in       = cnt_ff + LEN_W'(1);
               res_valid_in = 1'b1;
               res_mem_in   = 1'b1;
               res_len_in   = mlen_ff;
               res_last_in  = last_byte;
               if (last_byte) begin
                  state_in = BS_IDLE;
                  if (pos_next >= {1'b0, bank_used_ff[cur_bank_ff]}) begin
                     bank_head_in[cur_bank_ff] = '0;
                     bank_used_in[cur_bank_ff] = '0;
                  end else begin
                     bank_head_in[cur_bank_ff] = pos_next[PW-1:0];
                  end
               end
            end
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         bank_used_ff <= '{default: '0};
         bank_head_ff <= '{default: '0};
         read_bank_ff <= 1'b0;
         wrem_ff      <= '0;
         discard_ff   <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_used_ff <= bank_used_in;
         bank_head_ff <= bank_head_in;
         read_bank_ff <= read_bank_in;
         wrem_ff      <= wrem_in;
         discard_ff   <= discard_in;
         res_valid_ff <= res_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_bank_ff   <= cur_bank_in;
      pos_ff        <= pos_in;
      mlen_ff       <= mlen_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_len_ff    <= res_len_in;
      res_last_ff   <= res_last_in;
      res_mem_ff    <= res_mem_in;
   end

   // Byte store with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_ra];
      end
   end

   // Staged result into the result queue.
   assign rsp_push          = res_valid_ff;
   assign rsp_data.status   = res_status_ff;
   assign rsp_data.data     = res_mem_ff ? mem_q_ff : '0;
   assign rsp_data.length   = res_len_ff;
   assign rsp_data.last     = res_last_ff;

   `ASSERT_ALWAYS(len_after_dispatch, clock, reset,
      (state_ff == BS_LEN) |-> ($past(state_ff) == BS_IDLE))
   `ASSERT_ALWAYS(byte_from_data_state, clock, reset,
      (res_valid_ff && res_mem_ff) |-> ($past(state_ff) == BS_DATA))
   `ASSERT_ALWAYS(no_rsp_overflow, clock, reset,
      res_valid_ff |-> (rsp_count < RSP_CW'(RSP_DEPTH)))
   `ASSERT_ALWAYS(head_within_used, clock, reset,
      (bank_head_ff[0] <= bank_used_ff[0]) && (bank_head_ff[1] <= bank_used_ff[1]))
   `ASSERT_NEVER(discard_without_msg, clock, reset, (wrem_ff == '0) && discard_ff)

endmodule

`default_nettype wire

// ===== src/pplmb_rsp_fifo.sv =====
// Result queue that holds finished results until they are taken.
// Depends on pplmb_pkg.
`default_nettype none

module pplmb_rsp_fifo
   import pplmb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rsp_type           push_data,
   input  wire logic              pop,
   output logic                   empty,
   output rsp_type                head_data,
   output logic [RSP_CW-1:0]      count
);

   rsp_type             entry_ff [RSP_DEPTH];
   logic [RSP_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CW-1:0]   count_ff, count_in;
   logic                do_rd;

   // Occupancy; the back part never pushes without room.
   assign empty     = (count_ff == '0);
   assign count     = count_ff;
   assign head_data = entry_ff[rd_ptr_ff];
   assign do_rd     = pop && !empty;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + RSP_CW'(push) - RSP_CW'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire
